[rtl/core/fvs_pkg.sv]
package fvs_pkg;

    localparam int CORNER_W    = 12;
    localparam int NEW_INDEX_W = 14;
    localparam int VCOUNT_W    = 13;
    localparam int CORNERS     = 3;
    localparam int EPOCH_W     = 8;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 13'd4096;

    // Epoch zero marks entries that were swept by the clearing pass
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 8'hFF;

    typedef struct packed {
        logic [CORNER_W-1:0] corner_a;
        logic [CORNER_W-1:0] corner_b;
        logic [CORNER_W-1:0] corner_c;
        logic                first_of_mesh;
    } tri_t;

    typedef struct packed {
        logic [NEW_INDEX_W-1:0] new_index;
        logic                   allocates;
        logic [CORNER_W-1:0]    copy_source;
        logic                   overflow;
        logic                   last_corner;
    } corner_res_t;

    // Control from the sequencer to the allocation unit
    typedef struct packed {
        logic step;
        logic clear;
        logic use_remap;
        logic mark_prov;
        logic last;
    } alloc_ctl_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE0,
        ST_PROBE1,
        ST_PROBE2,
        ST_PICK,
        ST_READ,
        ST_EMIT
    } fvs_state_t;

endpackage

[rtl/core/fvs_stream_if.sv]
interface fvs_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

[rtl/core/fvs_table.sv]
module fvs_table
    import fvs_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 30
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/fvs_alloc.sv]
module fvs_alloc
    import fvs_pkg::*;
#(
    parameter int MAX_NEW_VERTICES = 16384,
    parameter int AW               = 12,
    parameter int RW               = 14
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  alloc_ctl_t                  ctl,
    input  logic [AW-1:0]               src,
    input  logic [2*EPOCH_W+RW-1:0]     word,
    input  logic [EPOCH_W-1:0]          epoch,
    output corner_res_t                 res,
    output logic                        wr_en,
    output logic [2*EPOCH_W+RW-1:0]     wr_word
);

    localparam int CW = $clog2(MAX_NEW_VERTICES + 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(MAX_NEW_VERTICES);
    localparam logic [NEW_INDEX_W-1:0] SAT_INDEX = NEW_INDEX_W'(MAX_NEW_VERTICES - 1);

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [EPOCH_W-1:0] remap_tag;
    logic [RW-1:0]      remap_idx;
    logic               hit;
    logic               full;
    logic               alloc;

    assign remap_tag = word[EPOCH_W+RW-1 -: EPOCH_W];
    assign remap_idx = word[RW-1:0];

    assign hit   = ctl.use_remap && (remap_tag == epoch);
    assign full  = (count_reg == CNT_FULL);
    assign alloc = !hit && !full;

    always_comb
    begin
        res = '0;
        res.last_corner = ctl.last;
        if (hit)
        begin
            res.new_index = NEW_INDEX_W'(remap_idx);
        end
        else if (full)
        begin
            res.new_index = SAT_INDEX;
            res.overflow  = 1'b1;
        end
        else
        begin
            res.new_index   = NEW_INDEX_W'(count_reg);
            res.allocates   = 1'b1;
            res.copy_source = CORNER_W'(src);
        end
    end

    // Mark the provoking corner and enter fresh allocations into the remap table
    always_comb
    begin
        wr_en   = ctl.step && (ctl.mark_prov || (alloc && ctl.use_remap));
        wr_word = word;
        if (ctl.mark_prov)
        begin
            wr_word[2*EPOCH_W+RW-1 -: EPOCH_W] = epoch;
        end
        if (alloc && ctl.use_remap)
        begin
            wr_word[EPOCH_W+RW-1 -: EPOCH_W] = epoch;
            wr_word[RW-1:0]                  = RW'(count_reg);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.clear)
        begin
            count_next = '0;
        end
        else if (ctl.step && alloc)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

[rtl/core/flat_shading_vertex_splitter_core.sv]
// Channel     Dir  Payload        Word
// ----------  ---  -------------  -----------------------------------------------
// triangle    in   tri_t          three corner indices and first_of_mesh
// result      out  corner_res_t   one corner: new index, copy source, flags
// cfg_wr_*    in   13-bit data    vertex_count, written when cfg_wr_en is high
//
// Take a triangle only in idle. The states PROBE0, PROBE1, PROBE2 and PICK probe the provoking
// tags through the one table read port, then each corner passes a READ and an EMIT state; the
// next triangle is taken once the last corner is emitted. After reset, sweep the table one
// entry a cycle (MAX_VERTICES entries, at most 4096) before triangle.ready rises; rerun the
// sweep when a new mesh starts once the 255 epoch tags are used up. A stalled result holds the
// sequencer before the next corner read.
module flat_shading_vertex_splitter_core
    import fvs_pkg::*;
#(
    parameter int MAX_VERTICES     = 4096,
    parameter int MAX_NEW_VERTICES = 16384
) (
    input  logic                clk,
    input  logic                rst_n,
    fvs_stream_if.sink          triangle,
    fvs_stream_if.source        result,
    input  logic                cfg_wr_en,
    input  logic [VCOUNT_W-1:0] cfg_wr_data
);

    // Table depth is bounded by the corner index width
    localparam int DEPTH = (MAX_VERTICES < (1 << CORNER_W)) ? MAX_VERTICES : (1 << CORNER_W);
    localparam int AW    = $clog2(DEPTH);
    localparam int NEW_W = $clog2(MAX_NEW_VERTICES);
    localparam int RW    = (NEW_W < NEW_INDEX_W) ? NEW_W : NEW_INDEX_W;
    localparam int DW    = 2 * EPOCH_W + RW;
    localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);
    localparam logic [1:0]    K_LAST   = 2'(CORNERS - 1);

    fvs_state_t          state_reg;
    fvs_state_t          state_next;
    logic [EPOCH_W-1:0]  epoch_reg;
    logic                pending_reg;
    logic [AW-1:0]       clr_addr_reg;
    logic [VCOUNT_W-1:0] vcount_reg;
    logic [AW-1:0]       c0_reg;
    logic [AW-1:0]       c1_reg;
    logic [AW-1:0]       c2_reg;
    logic [AW-1:0]       rc_reg [CORNERS];
    logic                free0_reg;
    logic                free1_reg;
    logic                found_reg;
    logic [1:0]          k_reg;
    logic                out_valid_reg;
    corner_res_t         out_data_reg;

    logic                accept;
    logic                clr_done;
    logic                out_free;
    logic                wrap;
    logic                tag_free;
    logic [AW-1:0]       ca;
    logic [AW-1:0]       cb;
    logic [AW-1:0]       cc;

    logic                tbl_wr_en;
    logic [AW-1:0]       tbl_wr_addr;
    logic [DW-1:0]       tbl_wr_data;
    logic                tbl_rd_en;
    logic [AW-1:0]       tbl_rd_addr;
    logic [DW-1:0]       tbl_rd_data;

    alloc_ctl_t          ctl;
    corner_res_t         alloc_res;
    logic                alloc_wr_en;
    logic [DW-1:0]       alloc_wr_word;

    // Replace out-of-range indices by zero
    function automatic logic [AW-1:0] clamp_index(input logic [CORNER_W-1:0] v,
                                                  input logic [VCOUNT_W-1:0] vc);
        logic bad;
        bad = ({1'b0, v} >= vc) || (32'(v) >= MAX_VERTICES);
        return bad ? '0 : AW'(v);
    endfunction

    assign ca = clamp_index(triangle.payload.corner_a, vcount_reg);
    assign cb = clamp_index(triangle.payload.corner_b, vcount_reg);
    assign cc = clamp_index(triangle.payload.corner_c, vcount_reg);

    assign accept   = triangle.valid && (state_reg == ST_IDLE);
    assign clr_done = (state_reg == ST_CLEAR) && (clr_addr_reg == CLR_LAST);
    assign out_free = !out_valid_reg || result.ready;
    assign wrap     = triangle.payload.first_of_mesh && (epoch_reg == EPOCH_LAST);
    assign tag_free = (tbl_rd_data[DW-1 -: EPOCH_W] != epoch_reg);

    assign triangle.ready = (state_reg == ST_IDLE);
    assign result.valid   = out_valid_reg;
    assign result.payload = out_data_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_done)
                begin
                    state_next = pending_reg ? ST_PROBE0 : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = wrap ? ST_CLEAR : ST_PROBE0;
                end
            end
            ST_PROBE0: state_next = ST_PROBE1;
            ST_PROBE1: state_next = ST_PROBE2;
            ST_PROBE2: state_next = ST_PICK;
            ST_PICK:   state_next = ST_READ;
            ST_READ:
            begin
                if (out_free)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                state_next = (k_reg == K_LAST) ? ST_IDLE : ST_READ;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Table ports and allocator control
    always_comb
    begin
        tbl_rd_en   = 1'b0;
        tbl_rd_addr = rc_reg[k_reg];
        tbl_wr_en   = 1'b0;
        tbl_wr_addr = rc_reg[k_reg];
        tbl_wr_data = alloc_wr_word;
        ctl         = '0;
        ctl.clear   = clr_done || (accept && triangle.payload.first_of_mesh && !wrap);
        ctl.use_remap = !((k_reg == 2'd0) && !found_reg);
        ctl.mark_prov = (k_reg == 2'd0) && found_reg;
        ctl.last      = (k_reg == K_LAST);
        case (state_reg)
            ST_CLEAR:
            begin
                tbl_wr_en   = 1'b1;
                tbl_wr_addr = clr_addr_reg;
                tbl_wr_data = '0;
            end
            ST_PROBE0:
            begin
                tbl_rd_en   = 1'b1;
                tbl_rd_addr = c0_reg;
            end
            ST_PROBE1:
            begin
                tbl_rd_en   = 1'b1;
                tbl_rd_addr = c1_reg;
            end
            ST_PROBE2:
            begin
                tbl_rd_en   = 1'b1;
                tbl_rd_addr = c2_reg;
            end
            ST_READ:
            begin
                tbl_rd_en = out_free;
            end
            ST_EMIT:
            begin
                ctl.step  = 1'b1;
                tbl_wr_en = alloc_wr_en;
            end
            default:
            begin
                tbl_rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            epoch_reg     <= EPOCH_FIRST;
            pending_reg   <= 1'b0;
            clr_addr_reg  <= '0;
            vcount_reg    <= VCOUNT_RESET;
            k_reg         <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                vcount_reg <= cfg_wr_data;
            end
            // Advance the sweep; restart the epochs once it is done
            if (state_reg == ST_CLEAR)
            begin
                if (clr_done)
                begin
                    clr_addr_reg <= '0;
                    epoch_reg    <= EPOCH_FIRST;
                    pending_reg  <= 1'b0;
                end
                else
                begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                end
            end
            if (accept && triangle.payload.first_of_mesh)
            begin
                if (wrap)
                begin
                    pending_reg <= 1'b1;
                end
                else
                begin
                    epoch_reg <= epoch_reg + EPOCH_W'(1);
                end
            end
            if (state_reg == ST_PICK)
            begin
                found_reg <= free0_reg || free1_reg || tag_free;
                k_reg     <= '0;
            end
            if (state_reg == ST_EMIT)
            begin
                k_reg <= k_reg + 2'd1;
            end
            if (state_reg == ST_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            c0_reg <= ca;
            c1_reg <= cb;
            c2_reg <= cc;
        end
        if (state_reg == ST_PROBE1)
        begin
            free0_reg <= tag_free;
        end
        if (state_reg == ST_PROBE2)
        begin
            free1_reg <= tag_free;
        end
        // Rotate so the first free corner leads; no free corner keeps the order
        if (state_reg == ST_PICK)
        begin
            if (!free0_reg && free1_reg)
            begin
                rc_reg[0] <= c1_reg;
                rc_reg[1] <= c2_reg;
                rc_reg[2] <= c0_reg;
            end
            else if (!free0_reg && !free1_reg && tag_free)
            begin
                rc_reg[0] <= c2_reg;
                rc_reg[1] <= c0_reg;
                rc_reg[2] <= c1_reg;
            end
            else
            begin
                rc_reg[0] <= c0_reg;
                rc_reg[1] <= c1_reg;
                rc_reg[2] <= c2_reg;
            end
        end
        if (state_reg == ST_EMIT)
        begin
            out_data_reg <= alloc_res;
        end
    end

    fvs_table #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (DW)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    fvs_alloc #(
        .MAX_NEW_VERTICES (MAX_NEW_VERTICES),
        .AW               (AW),
        .RW               (RW)
    ) u_alloc (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .src     (rc_reg[k_reg]),
        .word    (tbl_rd_data),
        .epoch   (epoch_reg),
        .res     (alloc_res),
        .wr_en   (alloc_wr_en),
        .wr_word (alloc_wr_word)
    );

endmodule
